@@ rtl/core/ispq_pkg.sv @@
// Shared types and codes for the interval set overlap query block.
`default_nettype none
package ispq_pkg;

    localparam int FIELD_BITS = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_EV,
        ST_QRY_EV,
        ST_UP,
        ST_UP_EV,
        ST_MRG_A,
        ST_MRG_B,
        ST_DN,
        ST_DN_EV,
        ST_DONE
    } back_state_t;

endpackage
`default_nettype wire

@@ rtl/core/ispq_front.sv @@
// Front end: sign-extends positions and tags items with start after stop.
`default_nettype none
module ispq_front #(
    parameter int POS_WIDTH = 32
) (
    input  wire logic [ispq_pkg::FIELD_BITS-1:0] start_in,
    input  wire logic [ispq_pkg::FIELD_BITS-1:0] stop_in,
    input  wire logic                            op_in,
    output logic      [2*POS_WIDTH+1:0]          item_out
);
    localparam int FB = ispq_pkg::FIELD_BITS;

    logic signed [POS_WIDTH-1:0] s_ext;
    logic signed [POS_WIDTH-1:0] e_ext;
    logic                        bad;

    generate
        if (POS_WIDTH <= FB) begin : g_narrow
            assign s_ext = $signed(start_in[POS_WIDTH-1:0]);
            assign e_ext = $signed(stop_in[POS_WIDTH-1:0]);
        end else begin : g_wide
            assign s_ext = {{(POS_WIDTH-FB){start_in[FB-1]}}, start_in};
            assign e_ext = {{(POS_WIDTH-FB){stop_in[FB-1]}}, stop_in};
        end
    endgenerate

    assign bad = s_ext > e_ext;
    // {op, bad, start, stop}
    assign item_out = {op_in, bad, s_ext, e_ext};
endmodule
`default_nettype wire

@@ rtl/core/ispq_fifo.sv @@
// Two-entry queue between the front and back ends.
`default_nettype none
module ispq_fifo #(
    parameter int WIDTH = 66
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_pop,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wp_reg, wp_next;
    logic             rp_reg, rp_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = slot_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= wr_data;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/ispq_back.sv @@
// Back end: interval table, binary search, shift sequencer and result register.
`default_nettype none
module ispq_back #(
    parameter int MAX_INTERVALS = 1024,
    parameter int POS_WIDTH     = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_valid,
    output logic                        q_pop,
    input  wire logic [2*POS_WIDTH+1:0] q_data,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output logic                        res_hit,
    output logic      [1:0]             res_status
);
    localparam int IW = $clog2(MAX_INTERVALS + 1);
    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int DW = 2 * POS_WIDTH;

    // entry = {start, stop}
    logic [DW-1:0] mem [MAX_INTERVALS];
    logic [DW-1:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [DW-1:0] mem_wd;

    ispq_pkg::back_state_t state_reg, state_next;
    logic [IW-1:0] count_reg, count_next;
    logic [IW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [IW-1:0] i_reg, i_next, k_reg, k_next, rem_reg, rem_next;
    logic          phase_reg, phase_next, op_reg, op_next;
    logic signed [POS_WIDTH-1:0] s_reg, s_next, e_reg, e_next, ms_reg, ms_next;
    logic          hit_reg, hit_next;
    ispq_pkg::status_t status_reg, status_next;
    logic          mvalid_reg, mvalid_next, mhit_reg, mhit_next;
    logic [1:0]    mstat_reg, mstat_next;

    logic [IW:0]   mid_sum, kr_sum;
    logic [IW-1:0] mid;
    logic signed [POS_WIDTH-1:0] rd_start, rd_stop;
    logic          go_right, out_free, q_bad, full;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[IW:1];
    assign kr_sum   = {1'b0, k_reg} + {1'b0, rem_reg};
    assign rd_start = $signed(rdata_reg[DW-1:POS_WIDTH]);
    assign rd_stop  = $signed(rdata_reg[POS_WIDTH-1:0]);
    assign go_right = phase_reg ? (rd_start <= e_reg) : (rd_stop < s_reg);
    assign out_free = !mvalid_reg || res_ready;
    assign q_bad    = q_data[DW];
    assign full     = count_reg == IW'(MAX_INTERVALS);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ispq_pkg::ST_IDLE:
                if (q_valid) state_next = q_bad ? ispq_pkg::ST_DONE : ispq_pkg::ST_SRCH;
            ispq_pkg::ST_SRCH:
                if (lo_reg < hi_reg) begin
                    state_next = ispq_pkg::ST_SRCH_EV;
                end else if (!phase_reg) begin
                    if (op_reg == ispq_pkg::OP_QUERY) begin
                        state_next = (lo_reg < count_reg) ? ispq_pkg::ST_QRY_EV
                                                          : ispq_pkg::ST_DONE;
                    end
                end else if (lo_reg == i_reg) begin
                    state_next = full ? ispq_pkg::ST_DONE : ispq_pkg::ST_UP;
                end else begin
                    state_next = ispq_pkg::ST_MRG_A;
                end
            ispq_pkg::ST_SRCH_EV: state_next = ispq_pkg::ST_SRCH;
            ispq_pkg::ST_QRY_EV:  state_next = ispq_pkg::ST_DONE;
            ispq_pkg::ST_UP:
                state_next = (k_reg > i_reg) ? ispq_pkg::ST_UP_EV : ispq_pkg::ST_DONE;
            ispq_pkg::ST_UP_EV:   state_next = ispq_pkg::ST_UP;
            ispq_pkg::ST_MRG_A:   state_next = ispq_pkg::ST_MRG_B;
            ispq_pkg::ST_MRG_B:   state_next = ispq_pkg::ST_DN;
            ispq_pkg::ST_DN:
                state_next = (kr_sum < {1'b0, count_reg}) ? ispq_pkg::ST_DN_EV
                                                          : ispq_pkg::ST_DONE;
            ispq_pkg::ST_DN_EV:   state_next = ispq_pkg::ST_DN;
            ispq_pkg::ST_DONE:
                if (out_free) state_next = ispq_pkg::ST_IDLE;
            default: state_next = ispq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        rem_next    = rem_reg;
        phase_next  = phase_reg;
        op_next     = op_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        ms_next     = ms_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        mvalid_next = mvalid_reg && !res_ready;
        mhit_next   = mhit_reg;
        mstat_next  = mstat_reg;
        q_pop       = 1'b0;
        raddr       = '0;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;
        unique case (state_reg)
            ispq_pkg::ST_IDLE:
                if (q_valid) begin
                    q_pop       = 1'b1;
                    op_next     = q_data[DW+1];
                    s_next      = $signed(q_data[DW-1:POS_WIDTH]);
                    e_next      = $signed(q_data[POS_WIDTH-1:0]);
                    hit_next    = q_bad && q_data[DW+1];
                    status_next = q_bad ? ispq_pkg::STATUS_BAD : ispq_pkg::STATUS_OK;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    phase_next  = 1'b0;
                end
            ispq_pkg::ST_SRCH:
                if (lo_reg < hi_reg) begin
                    raddr = mid[AW-1:0];
                end else if (!phase_reg) begin
                    i_next = lo_reg;
                    if (op_reg == ispq_pkg::OP_QUERY) begin
                        raddr    = lo_reg[AW-1:0];
                        hit_next = 1'b0;
                    end else begin
                        // second search: end of the overlapping run
                        phase_next = 1'b1;
                        hi_next    = count_reg;
                    end
                end else if (lo_reg == i_reg) begin
                    if (full) status_next = ispq_pkg::STATUS_FULL;
                    k_next = count_reg;
                end else begin
                    raddr    = i_reg[AW-1:0];
                    rem_next = lo_reg - i_reg - IW'(1);
                    k_next   = lo_reg - IW'(1);
                end
            ispq_pkg::ST_SRCH_EV:
                if (go_right) lo_next = mid + IW'(1);
                else hi_next = mid;
            ispq_pkg::ST_QRY_EV:
                hit_next = rd_start <= e_reg;
            ispq_pkg::ST_UP:
                if (k_reg > i_reg) begin
                    raddr = k_reg[AW-1:0] - AW'(1);
                end else begin
                    mem_we     = 1'b1;
                    mem_wa     = i_reg[AW-1:0];
                    mem_wd     = {s_reg, e_reg};
                    count_next = count_reg + IW'(1);
                end
            ispq_pkg::ST_UP_EV: begin
                mem_we = 1'b1;
                mem_wa = k_reg[AW-1:0];
                mem_wd = rdata_reg;
                k_next = k_reg - IW'(1);
            end
            ispq_pkg::ST_MRG_A: begin
                ms_next = (rd_start < s_reg) ? rd_start : s_reg;
                raddr   = k_reg[AW-1:0];
            end
            ispq_pkg::ST_MRG_B: begin
                mem_we = 1'b1;
                mem_wa = i_reg[AW-1:0];
                mem_wd = {ms_reg, ((rd_stop > e_reg) ? rd_stop : e_reg)};
                k_next = i_reg + IW'(1);
            end
            ispq_pkg::ST_DN:
                if (kr_sum < {1'b0, count_reg}) begin
                    raddr = kr_sum[AW-1:0];
                end else begin
                    count_next = count_reg - rem_reg;
                end
            ispq_pkg::ST_DN_EV: begin
                mem_we = 1'b1;
                mem_wa = k_reg[AW-1:0];
                mem_wd = rdata_reg;
                k_next = k_reg + IW'(1);
            end
            ispq_pkg::ST_DONE:
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mhit_next   = hit_reg;
                    mstat_next  = status_reg;
                end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ispq_pkg::ST_IDLE;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        rem_reg    <= rem_next;
        phase_reg  <= phase_next;
        op_reg     <= op_next;
        s_reg      <= s_next;
        e_reg      <= e_next;
        ms_reg     <= ms_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        mhit_reg   <= mhit_next;
        mstat_reg  <= mstat_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rdata_reg <= mem[raddr];
    end

    assign res_valid  = mvalid_reg;
    assign res_hit    = mhit_reg;
    assign res_status = mstat_reg;
endmodule
`default_nettype wire

@@ rtl/core/interval_set_overlap_query.sv @@
// Top level of the merged interval set with overlap query.
//
//  channel | dir | transaction
//  s_      | in  | one insert or query: tuser = operation, tdata = start_pos, stop_pos
//  m_      | out | one result per input: tdata = hit, status
//
// Query: a binary search over the single registered read port of the interval
// table for n stored intervals, then a read of the entry found.
// Insert: two binary searches, then for a new entry a shift up of every entry
// behind it, or for a merge a rewrite of the merged entry and a shift down of the
// entries behind the merged run, same read port.
// Start after stop skips the search. The table needs no clearing pass: reset
// only zeroes the entry count. A two-entry queue lets the input side keep
// taking transactions while the back end works or the result register stalls.
`default_nettype none
module interval_set_overlap_query #(
    parameter int MAX_INTERVALS = 1024,
    parameter int POS_WIDTH     = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] start_pos, [63:32] stop_pos
    input  wire logic [0:0]  s_tuser,   // [0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata    // [0] hit, [2:1] status, [7:3] zero
);
    localparam int QW = 2 * POS_WIDTH + 2;

    logic [QW-1:0] front_item, q_item;
    logic          q_valid, q_pop, res_hit;
    logic [1:0]    res_status;

    ispq_front #(.POS_WIDTH(POS_WIDTH)) u_front (
        .start_in (s_tdata[31:0]),
        .stop_in  (s_tdata[63:32]),
        .op_in    (s_tuser[0]),
        .item_out (front_item)
    );

    ispq_fifo #(.WIDTH(QW)) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (front_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_item)
    );

    ispq_back #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .POS_WIDTH     (POS_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_hit    (res_hit),
        .res_status (res_status)
    );

    assign m_tdata = {5'b0, res_status, res_hit};
endmodule
`default_nettype wire

@@ verif/interval_set_overlap_query_test.sv @@
// Self-checking testbench for the interval set overlap query block.
`timescale 1ns / 1ps
module interval_set_overlap_query_test;

    localparam int TABLE_DEPTH = 1024;
    localparam int STALL_LIMIT = 40000;  // cycles with no transaction on either side
    localparam int HOLD_CYCLES = 400;    // long result-side hold-off for backpressure
    localparam logic [31:0] POS_MIN = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
    localparam int FILL_BASE = 1000000;  // merge region, clear of the random window

    typedef struct packed {
        logic              hit;
        ispq_pkg::status_t status;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] start_pos, [63:32] stop_pos
    logic [0:0]  s_tuser;   // [0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] hit, [2:1] status, [7:3] zero

    interval_set_overlap_query dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Shadow copy of the interval table: sorted, disjoint, inclusive ends.
    longint span_lo[TABLE_DEPTH];
    longint span_hi[TABLE_DEPTH];
    int     span_cnt;

    answer_t pending_answers[$];
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_left;
    int      errors;
    int      items_sent;
    int      answers_seen;
    int      full_seen;
    int      hits_seen;
    int      quiet_cycles;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic spans_overlap(longint lo, longint hi);
        for (int k = 0; k < span_cnt; k++) begin
            if (span_lo[k] <= hi && span_hi[k] >= lo) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Insert with merge of overlapping entries (a shared endpoint counts); returns the status.
    function automatic ispq_pkg::status_t table_insert(longint lo, longint hi);
        int     i;
        int     j;
        int     gone;
        longint mlo;
        longint mhi;
        i = 0;
        while (i < span_cnt && span_hi[i] < lo) i++;
        j = i;
        while (j < span_cnt && span_lo[j] <= hi) j++;
        if (j == i) begin
            if (span_cnt >= TABLE_DEPTH) return ispq_pkg::STATUS_FULL;
            for (int k = span_cnt; k > i; k--) begin
                span_lo[k] = span_lo[k-1];
                span_hi[k] = span_hi[k-1];
            end
            span_lo[i] = lo;
            span_hi[i] = hi;
            span_cnt++;
            return ispq_pkg::STATUS_OK;
        end
        mlo = (span_lo[i] < lo) ? span_lo[i] : lo;
        mhi = (span_hi[j-1] > hi) ? span_hi[j-1] : hi;
        span_lo[i] = mlo;
        span_hi[i] = mhi;
        gone = j - i - 1;
        for (int k = i + 1; k + gone < span_cnt; k++) begin
            span_lo[k] = span_lo[k+gone];
            span_hi[k] = span_hi[k+gone];
        end
        span_cnt -= gone;
        return ispq_pkg::STATUS_OK;
    endfunction

    function automatic answer_t predict_answer(logic op, logic [31:0] s, logic [31:0] e);
        answer_t a;
        longint  lo;
        longint  hi;
        lo = longint'($signed(s));
        hi = longint'($signed(e));
        a.hit = 1'b0;
        a.status = ispq_pkg::STATUS_OK;
        if (lo > hi) begin
            // start after stop: no search, table untouched
            a.status = ispq_pkg::STATUS_BAD;
            a.hit = (op == ispq_pkg::OP_QUERY);
        end else if (op == ispq_pkg::OP_QUERY) begin
            a.hit = spans_overlap(lo, hi);
        end else begin
            a.status = table_insert(lo, hi);
        end
        return a;
    endfunction

    // Offer one transaction and hold it until accepted.
    task automatic send_item(input logic op, input logic [31:0] s, input logic [31:0] e);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {e, s};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_answers = {pending_answers, predict_answer(op, s, e)};
        items_sent++;
    endtask

    // Result side: check against the oldest expectation, then pick tready.
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata[0] !== want.hit) begin
                    $display("%0t: hit mismatch, expected %b, actual %b",
                             $time, want.hit, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[2:1] !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_tdata[2:1]);
                    errors++;
                end
                if (m_tdata[7:3] !== 5'd0) begin
                    $display("%0t: pad bits mismatch, expected 0, actual %b",
                             $time, m_tdata[7:3]);
                    errors++;
                end
                if (want.status == ispq_pkg::STATUS_FULL) full_seen++;
                if (want.hit) hits_seen++;
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles where no transaction moves on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("interval_set_overlap_query regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed();
        send_item(ispq_pkg::OP_INSERT, 32'd0, 32'd0);
        send_item(ispq_pkg::OP_QUERY,  32'd0, 32'd0);     // exact hit on a point
        send_item(ispq_pkg::OP_QUERY,  32'd1, 32'd1);     // one LSB away: miss
        send_item(ispq_pkg::OP_INSERT, 32'd1, 32'd1);     // adjacent point stays separate
        send_item(ispq_pkg::OP_INSERT, 32'd3, 32'd5);
        send_item(ispq_pkg::OP_INSERT, 32'd5, 32'd9);     // shares endpoint 5: merges
        send_item(ispq_pkg::OP_QUERY,  32'd9, 32'd20);
        send_item(ispq_pkg::OP_QUERY,  32'd10, 32'd20);
        send_item(ispq_pkg::OP_INSERT, POS_MIN, POS_MIN);
        send_item(ispq_pkg::OP_INSERT, POS_MAX, POS_MAX);
        send_item(ispq_pkg::OP_QUERY,  POS_MIN, POS_MIN);
        send_item(ispq_pkg::OP_QUERY,  POS_MAX, POS_MAX);
        send_item(ispq_pkg::OP_QUERY,  POS_MIN + 1, POS_MAX - 1);
        send_item(ispq_pkg::OP_QUERY,  32'd5, 32'd4);     // bad query reports hit
        send_item(ispq_pkg::OP_INSERT, 32'd9, 32'd2);     // bad insert leaves table
        send_item(ispq_pkg::OP_QUERY,  POS_MAX, POS_MIN);
        send_item(ispq_pkg::OP_INSERT, POS_MAX, POS_MIN);
        send_item(ispq_pkg::OP_INSERT, -32'sd100, 32'sd100); // swallows several entries
        send_item(ispq_pkg::OP_QUERY,  32'd101, 32'd101);
        send_item(ispq_pkg::OP_QUERY,  -32'sd101, -32'sd101);
        send_item(ispq_pkg::OP_QUERY,  -32'sd200, -32'sd100);
    endtask

    task automatic send_random_item();
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] t;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            // mostly well-formed items in a busy window so merges and shifts happen
            s = 32'($signed($urandom_range(0, 4095)) - 2048) * 16;
            e = s + $urandom_range(0, 48);
            if (pick < 8) begin
                t = s;
                s = e + 1;
                e = t;
            end
            send_item(logic'($urandom_range(0, 1)), s, e);
        end else begin
            // any bit pattern; wide inserts only when malformed
            s = $urandom;
            e = $urandom;
            if ($signed(s) > $signed(e)) send_item(logic'($urandom_range(0, 1)), s, e);
            else send_item(ispq_pkg::OP_QUERY, s, e);
        end
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_item();
    endtask

    // Result side stops for a long stretch while input keeps coming.
    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        repeat (12) send_random_item();
    endtask

    // Spread disjoint points, then one wide insert swallows them all.
    task automatic test_wide_merge();
        int p;
        p = FILL_BASE;
        repeat (32) begin
            send_item(ispq_pkg::OP_INSERT, 32'(p), 32'(p + $urandom_range(0, 1)));
            p += 4;
        end
        send_item(ispq_pkg::OP_QUERY,  32'(p - 4), 32'(p - 4));
        send_item(ispq_pkg::OP_INSERT, 32'(FILL_BASE - 8), 32'(p));
        send_item(ispq_pkg::OP_QUERY,  32'(FILL_BASE + 2), 32'(FILL_BASE + 2));
        send_item(ispq_pkg::OP_QUERY,  32'(p + 1), 32'(p + 1));
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0 && guard < STALL_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (64) @(posedge aclk);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ispq_pkg::OP_INSERT;
        m_tready  = 1'b0;
        span_cnt  = 0;
        hold_left = 0;
        errors = 0;
        items_sent = 0;
        answers_seen = 0;
        full_seen = 0;
        hits_seen = 0;
        quiet_cycles = 0;
        send_idle_pct = 11;
        recv_idle_pct = 68;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(250);
        send_idle_pct = 68;
        recv_idle_pct = 11;
        test_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(180);
        test_wide_merge();
        wait_drained();

        $display("covered %0d transactions (%0d results, %0d hits, %0d table-full)",
                 items_sent, answers_seen, hits_seen, full_seen);
        $display("directed edges, merges, malformed items, backpressure and a wide collapse");
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("interval_set_overlap_query regression: pass");
        end else begin
            $display("interval_set_overlap_query regression: fail");
        end
        $finish;
    end

endmodule

@@ interval_set_overlap_query.f @@
rtl/core/ispq_pkg.sv
rtl/core/ispq_front.sv
rtl/core/ispq_fifo.sv
rtl/core/ispq_back.sv
rtl/core/interval_set_overlap_query.sv
verif/interval_set_overlap_query_test.sv
